// ----- rtl/imgds_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the image downscaler.
// No dependencies; used by every module of the block.
package imgds_pkg;

  localparam int SampleW    = 8;
  localparam int SumW       = 16;
  localparam int AddW       = 10;   // sample times a weight of at most 4
  localparam int NumCh      = 3;
  localparam int FactorW    = 5;
  localparam int DimW       = 13;
  localparam int ColorW     = 2;
  localparam int CfgIdxW    = 2;
  localparam int RowW       = 12;
  localparam int HeightLimit = 4096;
  localparam int GaussFactor = 3;
  localparam int GaussDiv   = 16;

  // Block divisor d (fc*fc or 16) is replaced by a multiply with
  // ceil(2^RecipShift / d); exact for 16-bit sums while d < 2^DivisorW.
  localparam int DivisorW   = 2 * FactorW;
  localparam int RecipShift = SumW + DivisorW;
  localparam int RecipW     = RecipShift - 1;
  localparam int DvdW       = RecipShift + 1;

  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxFactor = 16;
  localparam int DefChannels  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE_FACTOR   = 2'd0,
    CFG_IN_WIDTH       = 2'd1,
    CFG_IN_HEIGHT      = 2'd2,
    CFG_COLOR_CHANNELS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] sample_0;
    logic [SampleW-1:0] sample_1;
    logic [SampleW-1:0] sample_2;
  } pix_t;

  typedef struct packed {
    logic [SampleW-1:0] result_0;
    logic [SampleW-1:0] result_1;
    logic [SampleW-1:0] result_2;
    logic               frame_end;
  } res_t;

  // one accumulate request, built in the accept cycle
  typedef struct packed {
    logic                       first;
    logic                       last;
    logic                       fend;
    logic                       gray;
    logic [NumCh-1:0][AddW-1:0] add;
  } acc_req_t;

  // finished block sums on their way to the scaler
  typedef struct packed {
    logic                       valid;
    logic                       fend;
    logic                       gray;
    logic [NumCh-1:0][SumW-1:0] sum;
  } acc_res_t;

  // values derived from the registers by the divider
  typedef struct packed {
    logic [DimW-1:0]   out_w;
    logic [DimW-1:0]   w_full;
    logic [DimW-1:0]   h_full;
    logic [RecipW-1:0] recip;
  } geom_t;

endpackage

// ----- rtl/imgds_geom_div.sv -----
`timescale 1ns / 1ps
// Shift-subtract divider that derives frame geometry and the scale reciprocal.
// Depends on imgds_pkg.
module imgds_geom_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [imgds_pkg::DimW-1:0]         w_i,
  input  logic [imgds_pkg::DimW-1:0]         h_i,
  input  logic [imgds_pkg::FactorW-1:0]      fc_i,
  input  logic [imgds_pkg::DivisorW-1:0]     dsr_i,
  output logic                               busy_o,
  output imgds_pkg::geom_t                   geom_o
);

  localparam int DvdW  = imgds_pkg::DvdW;
  localparam int DsrW  = imgds_pkg::DivisorW;
  localparam int DimW  = imgds_pkg::DimW;
  localparam int StepW = $clog2(DvdW);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN} st_e;
  typedef enum logic [1:0] {JOB_WIDTH, JOB_HEIGHT, JOB_RECIP} job_e;

  st_e              state_q;
  job_e             job_q;
  logic [StepW-1:0] step_q;
  logic [DvdW-1:0]  dvd_q;
  logic [DsrW-1:0]  dsr_q;
  logic [DsrW-1:0]  rem_q;
  imgds_pkg::geom_t geom_q;

  logic [DvdW-1:0]  op_dvd;
  logic [DsrW-1:0]  op_dsr;
  logic [DsrW:0]    shifted;
  logic             ge;
  logic [DsrW-1:0]  rem_d;
  logic [DvdW-1:0]  dvd_d;

  always_comb begin
    case (job_q)
      JOB_HEIGHT: begin
        op_dvd = DvdW'(h_i);
        op_dsr = DsrW'(fc_i);
      end
      JOB_RECIP: begin
        op_dvd = (DvdW'(1) << imgds_pkg::RecipShift) + DvdW'(dsr_i) - DvdW'(1);
        op_dsr = dsr_i;
      end
      default: begin
        op_dvd = DvdW'(w_i);
        op_dsr = DsrW'(fc_i);
      end
    endcase
  end

  // one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, dvd_q[DvdW-1]};
    ge      = (shifted >= {1'b0, dsr_q});
    rem_d   = ge ? DsrW'(shifted - {1'b0, dsr_q}) : DsrW'(shifted);
    dvd_d   = {dvd_q[DvdW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      job_q   <= JOB_WIDTH;
      step_q  <= '0;
      dvd_q   <= '0;
      dsr_q   <= '0;
      rem_q   <= '0;
      geom_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_LOAD;
            job_q   <= JOB_WIDTH;
          end
        end
        ST_LOAD: begin
          dvd_q   <= op_dvd;
          dsr_q   <= op_dsr;
          rem_q   <= '0;
          step_q  <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          dvd_q  <= dvd_d;
          rem_q  <= rem_d;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(DvdW - 1)) begin
            case (job_q)
              JOB_WIDTH: begin
                geom_q.out_w  <= DimW'(dvd_d);
                geom_q.w_full <= w_i - DimW'(rem_d);
                job_q         <= JOB_HEIGHT;
                state_q       <= ST_LOAD;
              end
              JOB_HEIGHT: begin
                geom_q.h_full <= h_i - DimW'(rem_d);
                job_q         <= JOB_RECIP;
                state_q       <= ST_LOAD;
              end
              default: begin
                geom_q.recip <= imgds_pkg::RecipW'(dvd_d);
                job_q        <= JOB_WIDTH;
                state_q      <= ST_IDLE;
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign geom_o = geom_q;

endmodule

// ----- rtl/imgds_band_acc.sv -----
`timescale 1ns / 1ps
// Band memory of per-column partial sums with read-modify-write and forwarding.
// Depends on imgds_pkg.
module imgds_band_acc #(
  parameter int MAX_WIDTH = imgds_pkg::DefMaxWidth,
  parameter int CHANNELS  = imgds_pkg::DefChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_WIDTH/2)-1:0] rd_idx_i,
  input  imgds_pkg::acc_req_t           req_i,
  output logic                          s1_res_o,
  output imgds_pkg::acc_res_t           res_o
);

  localparam int Depth = MAX_WIDTH / 2;
  localparam int IdxW  = $clog2(Depth);
  localparam int SumW  = imgds_pkg::SumW;
  localparam int NumCh = imgds_pkg::NumCh;
  localparam int Lanes = (CHANNELS >= 3) ? 3 : 1;
  localparam int MemW  = Lanes * SumW;

  logic [MemW-1:0] band_mem [Depth];
  logic [MemW-1:0] rdata_q;
  logic [MemW-1:0] fwd_data_q;
  logic [MemW-1:0] wdata;

  logic                s1_valid_q;
  logic                s1_fwd_q;
  logic [IdxW-1:0]     s1_idx_q;
  imgds_pkg::acc_req_t s1_req_q;

  logic                             res_valid_q;
  logic                             res_fend_q;
  logic                             res_gray_q;
  logic [NumCh-1:0][SumW-1:0]       res_sum_q;
  logic [NumCh-1:0][SumW-1:0]       new_sum;
  logic                             fwd_d;

  // same entry read in the cycle it is written: take the write data next cycle
  assign fwd_d = rd_en_i && s1_valid_q && (s1_idx_q == rd_idx_i);

  for (genvar l = 0; l < NumCh; l++) begin : g_lane
    if (l < Lanes) begin : g_live
      logic [SumW-1:0] base;
      assign base = s1_fwd_q ? fwd_data_q[l*SumW +: SumW] : rdata_q[l*SumW +: SumW];
      assign new_sum[l] = s1_req_q.first ? SumW'(s1_req_q.add[l])
                                         : base + SumW'(s1_req_q.add[l]);
      assign wdata[l*SumW +: SumW] = new_sum[l];
    end else begin : g_none
      assign new_sum[l] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= band_mem[rd_idx_i];
    end
    if (s1_valid_q) begin
      band_mem[s1_idx_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_fwd_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= rd_en_i;
      s1_fwd_q    <= fwd_d;
      res_valid_q <= s1_valid_q && s1_req_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      s1_idx_q <= rd_idx_i;
      s1_req_q <= req_i;
    end
    if (s1_valid_q) begin
      fwd_data_q <= wdata;
      res_fend_q <= s1_req_q.fend;
      res_gray_q <= s1_req_q.gray;
      res_sum_q  <= new_sum;
    end
  end

  assign s1_res_o    = s1_valid_q && s1_req_q.last;
  assign res_o.valid = res_valid_q;
  assign res_o.fend  = res_fend_q;
  assign res_o.gray  = res_gray_q;
  assign res_o.sum   = res_sum_q;

  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q)
    else $error("forward flag without a write in flight");

  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(s1_valid_q && s1_req_q.last))
    else $error("block result without a closing pixel");

endmodule

// ----- rtl/imgds_scale_out.sv -----
`timescale 1ns / 1ps
// Reciprocal multiply of block sums and the output register.
// Depends on imgds_pkg.
module imgds_scale_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  imgds_pkg::acc_res_t             res_i,
  input  logic [imgds_pkg::RecipW-1:0]    recip_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output imgds_pkg::res_t                 out_res_o
);

  localparam int ProdW = imgds_pkg::SumW + imgds_pkg::RecipW;
  localparam int NumCh = imgds_pkg::NumCh;
  localparam int SmpW  = imgds_pkg::SampleW;

  logic [NumCh-1:0][ProdW-1:0] prod;
  logic [NumCh-1:0][SmpW-1:0]  quo;
  logic                        out_valid_q;
  imgds_pkg::res_t             out_res_q;

  for (genvar c = 0; c < NumCh; c++) begin : g_mul
    assign prod[c] = ProdW'(res_i.sum[c]) * ProdW'(recip_i);
    assign quo[c]  = prod[c][imgds_pkg::RecipShift +: SmpW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_i.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      out_res_q.result_0  <= quo[0];
      out_res_q.result_1  <= res_i.gray ? '0 : quo[1];
      out_res_q.result_2  <= res_i.gray ? '0 : quo[2];
      out_res_q.frame_end <= res_i.fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> !(out_valid_q && out_stall_i))
    else $error("new result while the output request is stalled");

endmodule

// ----- rtl/image_downscale_box_gaussian.sv -----
`timescale 1ns / 1ps
// Top level of the integer-factor image downscaler (box mean / 3x3 Gaussian).
// Depends on imgds_pkg, imgds_geom_div, imgds_band_acc, imgds_scale_out.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in_valid_i/in_stall_o   | in_pix_i   (sample_0..sample_2)
//   out     | out_valid_o/out_stall_i | out_res_o  (result_0..2, frame_end)
//
// Flow: one pixel request per clock while in_stall_o is low. The band memory
// is read in the accept cycle and written back the next (back-to-back hits
// on one column are forwarded), then a block's sum is registered and scaled.
// A pixel that closes a block is held while an earlier result is still in
// the accumulate or scale stage, or the output request is full and stalled.
// Reset and every config write start the geometry divider: 3 jobs (width,
// height, reciprocal), with in_stall_o high and cfg_ready_o low meanwhile.
// The band memory is not cleared; each block's first pixel overwrites it.
module image_downscale_box_gaussian #(
  parameter int MAX_WIDTH  = imgds_pkg::DefMaxWidth,
  parameter int MAX_FACTOR = imgds_pkg::DefMaxFactor,
  parameter int CHANNELS   = imgds_pkg::DefChannels
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [imgds_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [imgds_pkg::DimW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  imgds_pkg::pix_t                  in_pix_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output imgds_pkg::res_t                  out_res_o
);

  localparam int DimW    = imgds_pkg::DimW;
  localparam int FactorW = imgds_pkg::FactorW;
  localparam int ColorW  = imgds_pkg::ColorW;
  localparam int RowW    = imgds_pkg::RowW;
  localparam int AddW    = imgds_pkg::AddW;
  localparam int DsrW    = imgds_pkg::DivisorW;
  localparam int ColW    = $clog2(MAX_WIDTH);
  localparam int OcW     = $clog2(MAX_WIDTH / 2);
  localparam int CibW    = $clog2(MAX_FACTOR);
  localparam int FcCmpW  = (CibW + 1 > FactorW) ? CibW + 1 : FactorW;

  localparam logic [FactorW-1:0] RstFactor = FactorW'(2);
  localparam logic [DimW-1:0]    RstWidth  = DimW'(4096);
  localparam logic [DimW-1:0]    RstHeight = DimW'(4096);
  localparam logic [ColorW-1:0]  ColorRgb  = ColorW'(3);

  // config registers
  logic [FactorW-1:0] factor_q;
  logic [DimW-1:0]    width_q;
  logic [DimW-1:0]    height_q;
  logic [ColorW-1:0]  color_q;

  // raster position
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CibW-1:0] cib_q, cib_d;
  logic [CibW-1:0] rib_q, rib_d;
  logic [OcW-1:0]  ocol_q, ocol_d;

  logic                is_gauss, is_box, active, gray;
  logic [FactorW-1:0]  fc;
  logic [DimW-1:0]     w_lim, h_lim;
  logic [DsrW-1:0]     dsr;
  logic                geo_busy;
  imgds_pkg::geom_t    geom;

  logic                in_range, blk_first, blk_last, blk_fend;
  logic [2:0]          wt;
  logic [imgds_pkg::NumCh-1:0][imgds_pkg::SampleW-1:0] samp;
  imgds_pkg::acc_req_t req;
  logic                in_acc, rd_en, cfg_acc;
  logic                s1_res;
  imgds_pkg::acc_res_t acc_res;

  logic [FcCmpW-1:0]   cib_inc, rib_inc;
  logic [DimW-1:0]     col_inc, row_inc;

  function automatic logic [1:0] gauss_weight(input logic [CibW-1:0] i);
    logic [1:0] w;
    if (i == CibW'(1)) begin
      w = 2'd2;
    end else if (i == CibW'(0) || i == CibW'(2)) begin
      w = 2'd1;
    end else begin
      w = 2'd0;
    end
    return w;
  endfunction

  // mode and limits from the registers
  always_comb begin
    is_gauss = (factor_q == FactorW'(imgds_pkg::GaussFactor));
    is_box   = (factor_q >= FactorW'(2)) && (32'(factor_q) <= 32'(MAX_FACTOR))
               && !factor_q[0];
    active   = is_gauss || is_box;
    fc       = active ? factor_q : FactorW'(1);
    gray     = !((color_q == ColorRgb) && (CHANNELS >= 3));

    w_lim = (32'(width_q) > 32'(MAX_WIDTH)) ? DimW'(MAX_WIDTH) : width_q;
    if (w_lim == '0) w_lim = DimW'(1);
    h_lim = (32'(height_q) > 32'(imgds_pkg::HeightLimit))
            ? DimW'(imgds_pkg::HeightLimit) : height_q;
    if (h_lim == '0) h_lim = DimW'(1);

    dsr = is_box ? DsrW'(fc) * DsrW'(fc) : DsrW'(imgds_pkg::GaussDiv);
  end

  // accept-cycle decode of the current pixel
  always_comb begin
    in_range  = active && (DimW'(col_q) < geom.w_full) && (DimW'(row_q) < geom.h_full)
                && (DimW'(ocol_q) < geom.out_w);
    blk_first = (rib_q == '0) && (cib_q == '0);
    blk_last  = (FcCmpW'(rib_q) + FcCmpW'(1) >= FcCmpW'(fc))
                && (FcCmpW'(cib_q) + FcCmpW'(1) >= FcCmpW'(fc));
    blk_fend  = (DimW'(ocol_q) + DimW'(1) == geom.out_w)
                && (DimW'(row_q) + DimW'(1) == geom.h_full);
    wt        = is_gauss ? 3'(gauss_weight(rib_q)) * 3'(gauss_weight(cib_q)) : 3'd1;

    samp[0] = in_pix_i.sample_0;
    samp[1] = in_pix_i.sample_1;
    samp[2] = in_pix_i.sample_2;

    req.first = blk_first;
    req.last  = blk_last;
    req.fend  = blk_fend;
    req.gray  = gray;
    for (int c = 0; c < imgds_pkg::NumCh; c++) begin
      req.add[c] = (c == 0 || !gray) ? AddW'(samp[c]) * AddW'(wt) : '0;
    end
  end

  // a block-closing pixel waits until the result path is clear
  assign in_stall_o  = geo_busy
                       || (in_range && blk_last
                           && (s1_res || acc_res.valid || (out_valid_o && out_stall_i)));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign rd_en       = in_acc && in_range;
  assign cfg_ready_o = !geo_busy;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // position update, runs for every accepted pixel
  always_comb begin
    cib_inc = FcCmpW'(cib_q) + FcCmpW'(1);
    rib_inc = FcCmpW'(rib_q) + FcCmpW'(1);
    col_inc = DimW'(col_q) + DimW'(1);
    row_inc = DimW'(row_q) + DimW'(1);

    cib_d  = CibW'(cib_inc);
    ocol_d = ocol_q;
    if (cib_inc >= FcCmpW'(fc)) begin
      cib_d  = '0;
      ocol_d = ocol_q + OcW'(1);
    end
    col_d = ColW'(col_inc);
    rib_d = rib_q;
    row_d = row_q;
    if (col_inc >= w_lim) begin
      col_d  = '0;
      cib_d  = '0;
      ocol_d = '0;
      rib_d  = (rib_inc >= FcCmpW'(fc)) ? '0 : CibW'(rib_inc);
      row_d  = RowW'(row_inc);
      if (row_inc >= h_lim) begin
        row_d = '0;
        rib_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= RstFactor;
      width_q  <= RstWidth;
      height_q <= RstHeight;
      color_q  <= ColorRgb;
      col_q    <= '0;
      row_q    <= '0;
      cib_q    <= '0;
      rib_q    <= '0;
      ocol_q   <= '0;
    end else begin
      if (cfg_acc) begin
        case (imgds_pkg::cfg_idx_e'(cfg_index_i))
          imgds_pkg::CFG_SCALE_FACTOR:   factor_q <= cfg_data_i[FactorW-1:0];
          imgds_pkg::CFG_IN_WIDTH:       width_q  <= cfg_data_i;
          imgds_pkg::CFG_IN_HEIGHT:      height_q <= cfg_data_i;
          imgds_pkg::CFG_COLOR_CHANNELS: color_q  <= cfg_data_i[ColorW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        col_q  <= col_d;
        row_q  <= row_d;
        cib_q  <= cib_d;
        rib_q  <= rib_d;
        ocol_q <= ocol_d;
      end
    end
  end

  imgds_geom_div u_geom_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_acc),
    .w_i     (w_lim),
    .h_i     (h_lim),
    .fc_i    (fc),
    .dsr_i   (dsr),
    .busy_o  (geo_busy),
    .geom_o  (geom)
  );

  imgds_band_acc #(
    .MAX_WIDTH (MAX_WIDTH),
    .CHANNELS  (CHANNELS)
  ) u_band_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_idx_i (ocol_q),
    .req_i    (req),
    .s1_res_o (s1_res),
    .res_o    (acc_res)
  );

  imgds_scale_out u_scale_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (acc_res),
    .recip_i     (geom.recip),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

  a_cfg_restarts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> geo_busy)
    else $error("config write did not restart the geometry divider");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for image_downscale_box_gaussian: whole frames under many settings.
// Needs imgds_pkg and the RTL of the downscaler; a built-in predictor checks every result.
module testbench;
  import imgds_pkg::*;

  localparam int BandDepth     = DefMaxWidth / 2;
  localparam int RandomPixels  = 480;   // pixels inside full blocks, random part
  localparam int DrainCycles   = 8;
  localparam int MaxReports    = 10;

  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_CHECKER} fill_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [DimW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  pix_t                in_pix_i;
  logic                out_valid_o;
  logic                out_stall_i;
  res_t                out_res_o;

  // register shadows, reset values
  logic [FactorW-1:0]  cfg_factor = 5'd2;
  logic [DimW-1:0]     cfg_width  = 13'd4096;
  logic [DimW-1:0]     cfg_height = 13'd4096;
  logic [ColorW-1:0]   cfg_color  = 2'd3;

  // predictor state
  logic [SumW-1:0]     band_acc [BandDepth][NumCh];
  int unsigned         col_pos, row_pos, col_blk, row_blk;
  logic [10:0]         out_col;
  res_t                expected_px [$];

  int                  mismatches;
  int unsigned         calm_left;

  image_downscale_box_gaussian u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pix_i    (in_pix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // effective frame size: zero acts as one, large values saturate
  function automatic int unsigned frame_cols();
    if (cfg_width == 0) return 1;
    return (cfg_width > DefMaxWidth) ? DefMaxWidth : cfg_width;
  endfunction

  function automatic int unsigned frame_rows();
    if (cfg_height == 0) return 1;
    return (cfg_height > HeightLimit) ? HeightLimit : cfg_height;
  endfunction

  function automatic bit factor_active(input int unsigned f);
    return (f == GaussFactor) || (f >= 2 && f <= DefMaxFactor && f % 2 == 0);
  endfunction

  function automatic int unsigned tap_weight(input int unsigned pos);
    case (pos)
      0, 2: return 1;
      1: return 2;
      default: return 0;
    endcase
  endfunction

  // Accumulate one pixel into its column's band sum; queue the reduced pixel
  // when it closes a block, then step the raster counters.
  task automatic predict_pixel(input pix_t p);
    int unsigned f, fc, fw, fh, ow, oh, wt, dv, nch;
    int unsigned smp [NumCh];
    bit          gauss, first, last;
    res_t        r;
    f     = cfg_factor;
    gauss = (f == GaussFactor);
    fc    = factor_active(f) ? f : 1;
    fw    = frame_cols();
    fh    = frame_rows();
    ow    = fw / fc;
    oh    = fh / fc;
    if (ow > BandDepth) ow = BandDepth;
    nch    = (cfg_color == 2'd3 && DefChannels >= 3) ? 3 : 1;
    smp[0] = p.sample_0;
    smp[1] = p.sample_1;
    smp[2] = p.sample_2;

    if (factor_active(f) && col_pos < ow * fc && row_pos < oh * fc && out_col < ow) begin
      wt    = gauss ? tap_weight(row_blk) * tap_weight(col_blk) : 1;
      first = (row_blk == 0 && col_blk == 0);
      last  = (row_blk + 1 >= fc && col_blk + 1 >= fc);
      for (int c = 0; c < NumCh; c++) begin
        band_acc[out_col][c] = SumW'((first ? 0 : int'(band_acc[out_col][c]))
                                     + ((c < nch) ? smp[c] * wt : 0));
      end
      if (last) begin
        dv          = gauss ? GaussDiv : fc * fc;
        r.result_0  = SampleW'(band_acc[out_col][0] / dv);
        r.result_1  = (nch == 3) ? SampleW'(band_acc[out_col][1] / dv) : '0;
        r.result_2  = (nch == 3) ? SampleW'(band_acc[out_col][2] / dv) : '0;
        r.frame_end = (out_col + 1 == ow) && (row_pos + 1 == oh * fc);
        expected_px.push_back(r);
      end
    end

    col_blk++;
    if (col_blk >= fc) begin
      col_blk = 0;
      out_col = out_col + 11'd1;
    end
    col_pos++;
    if (col_pos >= fw) begin
      col_pos = 0;
      col_blk = 0;
      out_col = '0;
      row_blk++;
      if (row_blk >= fc) row_blk = 0;
      row_pos++;
      if (row_pos >= fh) begin
        row_pos = 0;
        row_blk = 0;
      end
    end
  endtask

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_px.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: result with no block pending: %h", $time, got);
    end else begin
      want = expected_px.pop_front();
      if (got.result_0 != want.result_0) flag_mismatch("result_0", want.result_0, got.result_0);
      if (got.result_1 != want.result_1) flag_mismatch("result_1", want.result_1, got.result_1);
      if (got.result_2 != want.result_2) flag_mismatch("result_2", want.result_2, got.result_2);
      if (got.frame_end != want.frame_end)
        flag_mismatch("frame_end", want.frame_end, got.frame_end);
    end
  endtask

  // Everything is sampled before the edge's updates land, so register
  // writes, pixel requests and results are all seen in one place.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SCALE_FACTOR:   cfg_factor = cfg_data_i[FactorW-1:0];
          CFG_IN_WIDTH:       cfg_width  = cfg_data_i;
          CFG_IN_HEIGHT:      cfg_height = cfg_data_i;
          CFG_COLOR_CHANNELS: cfg_color  = cfg_data_i[ColorW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_pixel(in_pix_i);
      if (out_valid_o && !out_stall_i) check_result(out_res_o);
    end
  end

  // output backpressure: free runs of random length between stalls
  initial begin : out_stall_gen
    int unsigned run, hold;
    out_stall_i = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      repeat (run) @(negedge clk_i);
      hold = 1 + idle_len();
      @(negedge clk_i);
      out_stall_i <= 1'b1;
      repeat (hold - 1) @(negedge clk_i);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // One pixel request; valid stays up into the next call unless a gap follows.
  task automatic send_pixel(input pix_t p);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_pix_i   <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(20, 80);
      gap = idle_len();
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(input fill_e fill);
    int unsigned n;
    pix_t        p;
    n = frame_cols() * frame_rows();
    for (int unsigned k = 0; k < n; k++) begin
      case (fill)
        FILL_MAX:     p = '1;
        FILL_ZERO:    p = '0;
        FILL_CHECKER: p = (k % 2) ? {8'd0, 8'd255, 8'd0} : {8'd255, 8'd0, 8'd255};
        default:      p = 24'($urandom);
      endcase
      send_pixel(p);
    end
  endtask

  // Drop valid and let every pending result, and the pipeline behind it, drain.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DimW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Only at frame boundaries. Narrow registers sometimes get junk in the
  // unused upper data bits.
  task automatic set_mode(input logic [FactorW-1:0] f, input logic [DimW-1:0] w,
                          input logic [DimW-1:0] h, input logic [ColorW-1:0] color);
    logic [DimW-1:0] junk;
    wait_idle();
    junk = ($urandom_range(0, 3) == 0) ? DimW'($urandom) : '0;
    write_reg(CFG_SCALE_FACTOR, {junk[DimW-1:FactorW], f});
    write_reg(CFG_IN_WIDTH, w);
    write_reg(CFG_IN_HEIGHT, h);
    junk = ($urandom_range(0, 3) == 0) ? DimW'($urandom) : '0;
    write_reg(CFG_COLOR_CHANNELS, {junk[DimW-1:ColorW], color});
  endtask

  task automatic test_box_mean();
    set_mode(5'd2, 13'd2, 13'd2, 2'd3);
    send_frame(FILL_MAX);
  endtask

  // grayscale, odd size: last column and last row are dropped
  task automatic test_grayscale_trailing();
    set_mode(5'd2, 13'd3, 13'd3, 2'd1);
    send_frame(FILL_CHECKER);
  endtask

  task automatic test_gaussian();
    set_mode(5'd3, 13'd3, 13'd3, 2'd3);
    send_frame(FILL_CHECKER);
  endtask

  // factor one, odd other than three, zero: counters run, nothing comes out
  task automatic test_inactive_factors();
    set_mode(5'd1, 13'd2, 13'd1, 2'd3);
    send_frame(FILL_RANDOM);
    set_mode(5'd5, 13'd1, 13'd1, 2'd3);
    send_frame(FILL_RANDOM);
    set_mode(5'd0, 13'd0, 13'd0, 2'd0);
    send_frame(FILL_RANDOM);
  endtask

  // largest factor at full-scale sums
  task automatic test_largest_geometry();
    set_mode(5'd16, 13'd16, 13'd16, 2'd3);
    send_frame(FILL_MAX);
  endtask

  // Whole frames of random geometry and content; mostly active factors.
  task automatic test_random_frames();
    int unsigned useful, r, f, bw, bh, trim, w, h;
    logic [ColorW-1:0] color;
    fill_e fill;
    useful = 0;
    while (useful < RandomPixels) begin
      r = $urandom_range(0, 99);
      if (r < 30) f = 2;
      else if (r < 55) f = 3;
      else if (r < 72) f = 4;
      else if (r < 92) f = 2 * $urandom_range(3, 8);
      else begin
        case ($urandom_range(0, 2))
          0: f = $urandom_range(0, 1);
          1: f = 2 * $urandom_range(2, 7) + 1;
          default: f = $urandom_range(17, 31);
        endcase
      end
      if (factor_active(f)) begin
        bw   = (f >= 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        bh   = (f >= 8) ? 1 : $urandom_range(1, 3);
        trim = (f > 4) ? 3 : f - 1;
        w    = bw * f + $urandom_range(0, trim);
        h    = bh * f + $urandom_range(0, trim);
        useful += bw * f * bh * f;
      end else begin
        w = $urandom_range(0, 9);
        h = $urandom_range(0, 6);
      end
      r = $urandom_range(0, 9);
      color = (r < 5) ? 2'd3 : (r < 8) ? 2'd1 : ((r == 8) ? 2'd0 : 2'd2);
      r = $urandom_range(0, 19);
      fill = (r == 0) ? FILL_MAX : (r == 1) ? FILL_ZERO : FILL_RANDOM;
      set_mode(FactorW'(f), DimW'(w), DimW'(h), color);
      send_frame(fill);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SCALE_FACTOR;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_pix_i    = '0;
    col_pos     = 0;
    row_pos     = 0;
    col_blk     = 0;
    row_blk     = 0;
    out_col     = '0;
    mismatches  = 0;
    calm_left   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_box_mean();
    test_grayscale_trailing();
    test_gaussian();
    test_inactive_factors();
    test_largest_geometry();
    test_random_frames();

    wait_idle();
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("** image_downscale_box_gaussian: PASSED **");
    end else begin
      $display("** image_downscale_box_gaussian: FAILED **");
    end
    $finish;
  end

  // far beyond the slowest legal run of about a thousand pixels
  initial begin
    #50_000_000;
    $display("** image_downscale_box_gaussian: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/imgds_pkg.sv
rtl/imgds_geom_div.sv
rtl/imgds_band_acc.sv
rtl/imgds_scale_out.sv
rtl/image_downscale_box_gaussian.sv
verif/testbench.sv
